// ===== rtl/blbc_pkg.sv =====
package blbc_pkg;

	localparam int ENTRIES_DEF = 32;

	localparam int OP_W     = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 24;
	localparam int IDX_W    = 5;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 8;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_GET     = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
	localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// One table entry as stored in the entry memory.
	typedef struct packed {
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block;
		logic              assigned;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] rtime;
		logic              dvalid;
	} rec_t;

	// Scan unit control from the sequencer.
	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	// Saturating count increment.
	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

// ===== rtl/block_buffer_cache_lru.sv =====
// LRU disk block buffer cache, tag and bookkeeping only. A transaction is taken
// when start is high and busy is low; its result appears on entry, hit,
// needs_read and status for exactly one cycle with done high, and must be
// captured then, since there is no way to hold it off. A get walks the whole
// entry memory through its single read port, one entry per cycle, looking for
// the first matching assigned tag and the free entry with the oldest release
// time (lowest index on ties): after the drain and commit states done rises,
// and the next start is taken in that same cycle, so one get ends before the
// next is taken. Release, pin and unpin do one read of the addressed entry and,
// unless they underflow, one write; an entry_index beyond the table answers
// status ok in the cycle after accept and touches nothing. Counts saturate at
// 255, an unpin or release at count zero answers underflow, and a miss with
// every entry referenced answers no free buffer with entry 0. The table is
// ready right after reset: unwritten entries read as zero.
module block_buffer_cache_lru #(
	parameter int ENTRIES = blbc_pkg::ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [blbc_pkg::OP_W-1:0]       op,
	input  logic [blbc_pkg::DEV_W-1:0]      device,
	input  logic [blbc_pkg::BLK_W-1:0]      block_number,
	input  logic [blbc_pkg::IDX_W-1:0]      entry_index,
	input  logic [blbc_pkg::TIME_W-1:0]     now,
	output logic                            busy,
	output logic                            done,
	output logic [blbc_pkg::IDX_W-1:0]      entry,
	output logic                            hit,
	output logic                            needs_read,
	output logic [blbc_pkg::STATUS_W-1:0]   status
);

	localparam int AW = $clog2(ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_READ,
		ST_MODIFY
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   ptr_q;
	logic                            done_q;
	logic [blbc_pkg::IDX_W-1:0]      entry_q;
	logic                            hit_q;
	logic                            needs_read_q;
	logic [blbc_pkg::STATUS_W-1:0]   status_q;

	// Transaction fields held while the transaction is in flight.
	logic [blbc_pkg::OP_W-1:0]       op_q;
	logic [blbc_pkg::DEV_W-1:0]      device_q;
	logic [blbc_pkg::BLK_W-1:0]      block_q;
	logic [blbc_pkg::IDX_W-1:0]      entry_index_q;
	logic [blbc_pkg::TIME_W-1:0]     now_q;

	// Read pipeline: which entry the memory data belongs to.
	logic                            samp_s1;
	logic [AW-1:0]                   samp_idx_s1;

	logic                            accept;
	logic                            in_range;
	blbc_pkg::scan_ctl_t             scan_ctl;

	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	blbc_pkg::rec_t                  rd_rec;
	logic                            wr_en;
	logic [AW-1:0]                   wr_addr;
	blbc_pkg::rec_t                  wr_data;

	logic                            scan_hit;
	logic [AW-1:0]                   scan_hit_idx;
	blbc_pkg::rec_t                  scan_hit_rec;
	logic                            scan_free;
	logic [AW-1:0]                   scan_free_idx;
	logic [blbc_pkg::TIME_W-1:0]     scan_free_time;

	logic [blbc_pkg::IDX_W-1:0]      res_entry;
	logic                            res_hit;
	logic                            res_rd;
	logic [blbc_pkg::STATUS_W-1:0]   res_status;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_range = (32'(entry_index) < 32'(ENTRIES));

	assign scan_ctl.clear  = accept && (op == blbc_pkg::OP_GET);
	assign scan_ctl.sample = samp_s1;

	blbc_mem #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	blbc_scan #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (samp_idx_s1),
		.rec        (rd_rec),
		.device     (device_q),
		.block      (block_q),
		.hit_found  (scan_hit),
		.hit_idx    (scan_hit_idx),
		.hit_rec    (scan_hit_rec),
		.free_found (scan_free),
		.free_idx   (scan_free_idx),
		.free_time  (scan_free_time)
	);

	// Memory access and the read-modify-write decision for the closing cycle.
	always_comb begin
		rd_en      = (state_q == ST_SCAN) || (state_q == ST_READ);
		rd_addr    = (state_q == ST_SCAN) ? ptr_q : AW'(entry_index_q);
		wr_en      = 1'b0;
		wr_addr    = AW'(entry_index_q);
		wr_data    = rd_rec;
		res_entry  = entry_index_q;
		res_hit    = 1'b0;
		res_rd     = 1'b0;
		res_status = blbc_pkg::STATUS_OK;
		case (state_q)
			ST_COMMIT: begin
				if (scan_hit) begin
					// Hit: bump the count, mark data valid, keep tag and time.
					wr_en          = 1'b1;
					wr_addr        = scan_hit_idx;
					wr_data        = scan_hit_rec;
					wr_data.count  = blbc_pkg::cnt_inc(scan_hit_rec.count);
					wr_data.dvalid = 1'b1;
					res_entry      = (blbc_pkg::IDX_W)'(scan_hit_idx);
					res_hit        = 1'b1;
					res_rd         = !scan_hit_rec.dvalid;
				end else if (scan_free) begin
					// Miss: retag the oldest free entry, keep its release time.
					wr_en            = 1'b1;
					wr_addr          = scan_free_idx;
					wr_data.device   = device_q;
					wr_data.block    = block_q;
					wr_data.assigned = 1'b1;
					wr_data.count    = blbc_pkg::CNT_ONE;
					wr_data.rtime    = scan_free_time;
					wr_data.dvalid   = 1'b1;
					res_entry        = (blbc_pkg::IDX_W)'(scan_free_idx);
					res_rd           = 1'b1;
				end else begin
					res_entry  = '0;
					res_status = blbc_pkg::STATUS_NO_FREE;
				end
			end
			ST_MODIFY: begin
				if (op_q == blbc_pkg::OP_PIN) begin
					wr_en         = 1'b1;
					wr_data.count = blbc_pkg::cnt_inc(rd_rec.count);
				end else if (rd_rec.count == '0) begin
					res_status = blbc_pkg::STATUS_UNDERFLOW;
				end else begin
					wr_en         = 1'b1;
					wr_data.count = rd_rec.count - 1'b1;
					// Stamp the time only on the release that frees the entry.
					if ((op_q == blbc_pkg::OP_RELEASE) &&
						(rd_rec.count == blbc_pkg::CNT_ONE)) begin
						wr_data.rtime = now_q;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer: state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ptr_q        <= '0;
			done_q       <= 1'b0;
			entry_q      <= '0;
			hit_q        <= 1'b0;
			needs_read_q <= 1'b0;
			status_q     <= blbc_pkg::STATUS_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == blbc_pkg::OP_GET) begin
							state_q <= ST_SCAN;
							ptr_q   <= '0;
						end else if (in_range) begin
							state_q <= ST_READ;
						end else begin
							// Drop an entry beyond the table: answer at once.
							done_q       <= 1'b1;
							entry_q      <= entry_index;
							hit_q        <= 1'b0;
							needs_read_q <= 1'b0;
							status_q     <= blbc_pkg::STATUS_OK;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == AW'(ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_READ: begin
					state_q <= ST_MODIFY;
				end
				ST_COMMIT, ST_MODIFY: begin
					state_q      <= ST_IDLE;
					done_q       <= 1'b1;
					entry_q      <= res_entry;
					hit_q        <= res_hit;
					needs_read_q <= res_rd;
					status_q     <= res_status;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_s1 <= 1'b0;
		end else begin
			samp_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		samp_idx_s1 <= ptr_q;
		if (accept) begin
			op_q          <= op;
			device_q      <= device;
			block_q       <= block_number;
			entry_index_q <= entry_index;
			now_q         <= now;
		end
	end

	assign done       = done_q;
	assign entry      = entry_q;
	assign hit        = hit_q;
	assign needs_read = needs_read_q;
	assign status     = status_q;

	// A result only follows a closing cycle or an out-of-table accept.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_COMMIT) || ($past(state_q) == ST_MODIFY) ||
			$past(start && !busy))
		else $error("result without a finished transaction");

	// The scan walks the table one entry per cycle.
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && ($past(state_q) == ST_SCAN) |->
			ptr_q == AW'($past(ptr_q) + 1'b1))
		else $error("scan pointer skipped");

	// Assigned entries always carry valid data, so a hit never needs a read.
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !needs_read && (status == blbc_pkg::STATUS_OK))
		else $error("hit with invalid data or bad status");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < 32'(ENTRIES)))
		else $error("write beyond the table");

endmodule

// ===== rtl/blbc_mem.sv =====
module blbc_mem #(
	parameter int ENTRIES = blbc_pkg::ENTRIES_DEF,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output blbc_pkg::rec_t       rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  blbc_pkg::rec_t       wr_data
);

	blbc_pkg::rec_t       mem_q [ENTRIES];
	blbc_pkg::rec_t       rd_raw_q;
	logic [ENTRIES-1:0]   written_q;
	logic                 rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	// Entries never written read as the all-zero reset record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule

// ===== rtl/blbc_scan.sv =====
module blbc_scan #(
	parameter int ENTRIES = blbc_pkg::ENTRIES_DEF,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  blbc_pkg::scan_ctl_t           ctl,
	input  logic [AW-1:0]                 idx,
	input  blbc_pkg::rec_t                rec,
	input  logic [blbc_pkg::DEV_W-1:0]    device,
	input  logic [blbc_pkg::BLK_W-1:0]    block,
	output logic                          hit_found,
	output logic [AW-1:0]                 hit_idx,
	output blbc_pkg::rec_t                hit_rec,
	output logic                          free_found,
	output logic [AW-1:0]                 free_idx,
	output logic [blbc_pkg::TIME_W-1:0]   free_time
);

	logic                        hit_found_q;
	logic                        free_found_q;
	logic [AW-1:0]               hit_idx_q;
	logic [AW-1:0]               free_idx_q;
	blbc_pkg::rec_t              hit_rec_q;
	logic [blbc_pkg::TIME_W-1:0] free_time_q;
	logic                        is_hit;
	logic                        is_better;

	// Keep the first tag match; keep a free entry only on a strictly older time.
	assign is_hit = ctl.sample && !hit_found_q && rec.assigned &&
		(rec.device == device) && (rec.block == block);
	assign is_better = ctl.sample && (rec.count == '0) &&
		(!free_found_q || (rec.rtime < free_time_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (is_hit) begin
				hit_found_q <= 1'b1;
			end
			if (is_better) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_hit) begin
			hit_idx_q <= idx;
			hit_rec_q <= rec;
		end
		if (is_better) begin
			free_idx_q  <= idx;
			free_time_q <= rec.rtime;
		end
	end

	assign hit_found  = hit_found_q;
	assign hit_idx    = hit_idx_q;
	assign hit_rec    = hit_rec_q;
	assign free_found = free_found_q;
	assign free_idx   = free_idx_q;
	assign free_time  = free_time_q;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import blbc_pkg::*;

	localparam int ITEM_TARGET   = 1550;
	localparam int TAIL_ITEMS    = 150;   // final stretch runs without sender gaps
	localparam int QUIET_LIMIT   = 4000;  // cycles with no transaction and no result
	localparam int SETTLE_CYCLES = 40;
	localparam int POOL          = 16;

	// One answer of the cache, field by field as on the result ports.
	typedef struct packed {
		logic [IDX_W-1:0]    entry;
		logic                hit;
		logic                needs_read;
		logic [STATUS_W-1:0] status;
	} cache_reply_t;

	// Shadow of the entry table plus the queue of answers still owed by the block.
	class cache_scoreboard;
		logic [DEV_W-1:0]  dev_tag  [ENTRIES_DEF];
		logic [BLK_W-1:0]  blk_tag  [ENTRIES_DEF];
		logic              assigned [ENTRIES_DEF];
		logic [CNT_W-1:0]  ref_cnt  [ENTRIES_DEF];
		logic [TIME_W-1:0] rel_time [ENTRIES_DEF];
		logic              valid    [ENTRIES_DEF];
		cache_reply_t      owed_q[$];
		int                errors;

		function new();
			for (int i = 0; i < ENTRIES_DEF; i++) begin
				dev_tag[i]  = '0;
				blk_tag[i]  = '0;
				assigned[i] = 1'b0;
				ref_cnt[i]  = '0;
				rel_time[i] = '0;
				valid[i]    = 1'b0;
			end
			errors = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Apply one accepted transaction to the shadow table and queue its answer.
		function void note_request(input logic [OP_W-1:0] op, input logic [DEV_W-1:0] dev,
				input logic [BLK_W-1:0] blk, input logic [IDX_W-1:0] idx,
				input logic [TIME_W-1:0] stamp);
			cache_reply_t r;
			int           pick;
			bit           found;
			r = '{entry: '0, hit: 1'b0, needs_read: 1'b0, status: STATUS_OK};
			pick = 0;
			found = 1'b0;
			if (op == OP_GET) begin
				for (int i = 0; i < ENTRIES_DEF; i++) begin
					if (assigned[i] && dev_tag[i] == dev && blk_tag[i] == blk) begin
						pick = i;
						found = 1'b1;
						break;
					end
				end
				if (found) begin
					if (ref_cnt[pick] != CNT_MAX)
						ref_cnt[pick] = ref_cnt[pick] + 1'b1;
					r.entry = IDX_W'(pick);
					r.hit = 1'b1;
					r.needs_read = !valid[pick];
					valid[pick] = 1'b1;
				end else begin
					// Oldest release time among unreferenced entries, lowest index on ties.
					for (int i = 0; i < ENTRIES_DEF; i++) begin
						if (ref_cnt[i] == '0 && (!found || rel_time[i] < rel_time[pick])) begin
							pick = i;
							found = 1'b1;
						end
					end
					if (!found) begin
						r.status = STATUS_NO_FREE;
					end else begin
						dev_tag[pick]  = dev;
						blk_tag[pick]  = blk;
						assigned[pick] = 1'b1;
						ref_cnt[pick]  = CNT_W'(1);
						valid[pick]    = 1'b1;
						r.entry = IDX_W'(pick);
						r.needs_read = 1'b1;
					end
				end
			end else begin
				r.entry = idx;
				if (int'(idx) < ENTRIES_DEF) begin
					if (op == OP_PIN) begin
						if (ref_cnt[idx] != CNT_MAX)
							ref_cnt[idx] = ref_cnt[idx] + 1'b1;
					end else if (ref_cnt[idx] == '0) begin
						r.status = STATUS_UNDERFLOW;
					end else begin
						ref_cnt[idx] = ref_cnt[idx] - 1'b1;
						if (op == OP_RELEASE && ref_cnt[idx] == '0)
							rel_time[idx] = stamp;
					end
				end
			end
			owed_q.push_back(r);
		endfunction

		// Compare one strobed answer with the oldest one owed.
		function void check_result(input cache_reply_t got);
			cache_reply_t want;
			if (owed_q.size() == 0) begin
				$error("result with nothing pending: entry %0d status %0d", got.entry, got.status);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.entry !== want.entry) begin
				$error("entry: expected %0d, got %0d", want.entry, got.entry);
				errors++;
			end
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			if (got.needs_read !== want.needs_read) begin
				$error("needs_read: expected %0d, got %0d", want.needs_read, got.needs_read);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [OP_W-1:0]     op           = OP_GET;
	logic [DEV_W-1:0]    device       = '0;
	logic [BLK_W-1:0]    block_number = '0;
	logic [IDX_W-1:0]    entry_index  = '0;
	logic [TIME_W-1:0]   now          = '0;
	logic                busy;
	logic                done;
	logic [IDX_W-1:0]    entry;
	logic                hit;
	logic                needs_read;
	logic [STATUS_W-1:0] status;

	cache_scoreboard   sb;
	int                sent = 0;
	int                idle_pct = 0;
	int                quiet_cycles = 0;
	logic [TIME_W-1:0] tick = '0;
	logic [TIME_W-1:0] last_stamp = '0;
	logic [DEV_W-1:0]  pool_dev [POOL];
	logic [BLK_W-1:0]  pool_blk [POOL];

	block_buffer_cache_lru uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.op           (op),
		.device       (device),
		.block_number (block_number),
		.entry_index  (entry_index),
		.now          (now),
		.busy         (busy),
		.done         (done),
		.entry        (entry),
		.hit          (hit),
		.needs_read   (needs_read),
		.status       (status)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Results cannot be held off: grab every strobed answer at the edge that ends it.
	always @(posedge clk) begin
		if (done)
			sb.check_result(cache_reply_t'{entry, hit, needs_read, status});
	end

	// Watchdog: trip when neither a transaction nor a result moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Time stamps: mostly advancing, sometimes zero, the maximum, a repeat or anything.
	function automatic logic [TIME_W-1:0] next_stamp();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return last_stamp;
			3: begin
				last_stamp = TIME_W'($urandom);
				return last_stamp;
			end
			default: begin
				tick = tick + TIME_W'($urandom_range(1, 500));
				last_stamp = tick;
				return tick;
			end
		endcase
	endfunction

	// Pick an entry that currently holds a reference, so releases mostly succeed.
	function automatic logic [IDX_W-1:0] pick_held();
		int held[$];
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (sb.ref_cnt[i] != '0)
				held.push_back(i);
		if (held.size() == 0)
			return IDX_W'($urandom);
		return IDX_W'(held[$urandom_range(0, held.size() - 1)]);
	endfunction

	function automatic int free_entries();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (sb.ref_cnt[i] == '0)
				n++;
		return n;
	endfunction

	// Drive one transaction, hold it until taken, then maybe drop start for a gap.
	task automatic send(input logic [OP_W-1:0] o, input logic [DEV_W-1:0] d,
			input logic [BLK_W-1:0] b, input logic [IDX_W-1:0] x, input logic [TIME_W-1:0] t);
		start        <= 1'b1;
		op           <= o;
		device       <= d;
		block_number <= b;
		entry_index  <= x;
		now          <= t;
		do @(posedge clk); while (busy);
		sb.note_request(o, d, b, x, t);
		sent++;
		if (sent < ITEM_TARGET - TAIL_ITEMS && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Get: entry_index and now carry junk, the block must ignore them.
	task automatic do_get(input logic [DEV_W-1:0] d, input logic [BLK_W-1:0] b);
		send(OP_GET, d, b, IDX_W'($urandom), TIME_W'($urandom));
	endtask

	// Release, pin, unpin: device and block_number carry junk.
	task automatic do_idx(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] x,
			input logic [TIME_W-1:0] t);
		send(o, DEV_W'($urandom), BLK_W'($urandom), x, t);
	endtask

	// Drop start and wait on clock edges until every owed answer is back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic directed();
		do_get(8'd0, 24'd0);                          // unassigned entry must not hit on a zero tag
		do_get(8'd0, 24'd0);                          // hit, data already valid
		do_get(8'hFF, 24'hFFFFFF);                    // miss into the next free entry
		do_idx(OP_UNPIN, 5'd1, '0);                   // count to zero, no stamp
		do_idx(OP_UNPIN, 5'd1, '0);                   // underflow
		do_idx(OP_RELEASE, 5'd1, '1);                 // underflow on release
		do_idx(OP_PIN, 5'd31, '0);                    // pin an unassigned entry
		do_idx(OP_UNPIN, 5'd31, '0);
		do_idx(OP_RELEASE, 5'd0, '1);
		do_idx(OP_RELEASE, 5'd0, '1);                 // final release stamps the maximum time
		do_get(8'h00, 24'hFFFFFF);                    // tie at time zero goes to lowest index
		do_get(8'hFF, 24'h000000);
		do_idx(OP_RELEASE, 5'd2, 32'd5);
		do_get(8'hFF, 24'hFFFFFF);                    // old tag was retagged away: miss
		do_idx(OP_RELEASE, 5'd31, '0);                // underflow on an idle entry
		do_idx(OP_PIN, 5'd0, 32'h8000_0000);
		do_idx(OP_UNPIN, 5'd0, 32'h7FFF_FFFF);
		do_get(8'h80, 24'h800000);
		do_get(8'h7F, 24'h7FFFFF);
		do_get(8'hFF, 24'h000000);                    // hit on an unreferenced but assigned entry
		do_idx(OP_RELEASE, 5'd2, 32'h0000_0001);
		do_idx(OP_RELEASE, 5'd16, 32'hA5A5_A5A5);
	endtask

	// Drive one entry into count saturation, hit it while saturated, then unwind past zero.
	task automatic pin_storm();
		logic [IDX_W-1:0] x;
		x = IDX_W'($urandom);
		repeat (260) do_idx(OP_PIN, x, next_stamp());
		if (sb.assigned[x])
			do_get(sb.dev_tag[x], sb.blk_tag[x]);
		repeat (258) do_idx(OP_UNPIN, x, next_stamp());
		do_idx(OP_RELEASE, x, next_stamp());
	endtask

	// Reference every entry, run into no free buffer, then release all in shuffled order.
	task automatic fill_and_release();
		int guard;
		int order[$];
		int j;
		int tmp;
		int k;
		guard = 0;
		while (free_entries() != 0 && guard < 40) begin
			do_get(DEV_W'($urandom), BLK_W'($urandom));
			guard++;
		end
		repeat ($urandom_range(1, 3)) do_get(DEV_W'($urandom), BLK_W'($urandom));
		k = $urandom_range(0, POOL - 1);
		do_get(pool_dev[k], pool_blk[k]);
		for (int i = 0; i < ENTRIES_DEF; i++)
			if (sb.ref_cnt[i] != '0)
				order.push_back(i);
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i])
			while (sb.ref_cnt[order[i]] != '0)
				do_idx(OP_RELEASE, IDX_W'(order[i]), next_stamp());
	endtask

	// Mixed traffic over a small tag pool so hits, misses and evictions interleave.
	task automatic random_mix(input int n);
		int r;
		int k;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 38) begin
				if ($urandom_range(0, 4) != 0) begin
					k = $urandom_range(0, POOL - 1);
					do_get(pool_dev[k], pool_blk[k]);
				end else begin
					do_get(DEV_W'($urandom), BLK_W'($urandom));
				end
			end else if (r < 80) begin
				do_idx(OP_RELEASE, ($urandom_range(0, 6) != 0) ? pick_held() : IDX_W'($urandom),
					next_stamp());
			end else if (r < 88) begin
				do_idx(OP_PIN, IDX_W'($urandom), next_stamp());
			end else begin
				do_idx(OP_UNPIN, ($urandom_range(0, 9) < 7) ? pick_held() : IDX_W'($urandom),
					next_stamp());
			end
		end
	endtask

	initial begin
		sb = new();
		// Small pool with near-miss tags: same device other block and the reverse.
		for (int i = 0; i < POOL; i++) begin
			pool_dev[i] = DEV_W'($urandom_range(0, 3));
			pool_blk[i] = BLK_W'($urandom_range(0, 7));
		end
		pool_dev[0] = '0;
		pool_blk[0] = '0;
		pool_dev[1] = '1;
		pool_blk[1] = '1;
		pool_blk[2] = '1;
		pool_dev[3] = '1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		idle_pct = 20;
		directed();
		drain();
		pin_storm();

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			// No pauses in the final stretch.
			if (sent < ITEM_TARGET - TAIL_ITEMS && $urandom_range(0, 4) == 0)
				drain();
			if ($urandom_range(0, 5) == 0)
				fill_and_release();
			else
				random_mix($urandom_range(10, 40));
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
